>>> rtl/core/sha256_pkg.sv
// Package: SHA-256 item types, constants and round functions.
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Round constants.
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction

	// Round control from the sequencer to the round unit.
	typedef struct packed {
		logic       load;   // copy hash words into working words
		logic       round;  // run one round
		logic       fold;   // add working words into hash words
		logic       init;   // return hash words to initial values
		logic [5:0] t;      // round number
	} rnd_ctl_t;

endpackage

>>> rtl/core/sha256_round.sv
// Shared round unit: schedule window, working words and hash words.
module sha256_compress_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha256_pkg::rnd_ctl_t  ctl,
	input  logic [31:0]           msg_word,
	input  logic [2:0]            rd_index,
	output logic [31:0]           rd_word
);
	import sha256_pkg::*;

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [31:0] w15, w2, w7, w16, g0, g1, wt, s0, s1, ch, maj, t1, t2;

	// Schedule and round arithmetic.
	always_comb begin
		w16 = w_q[0];
		w15 = w_q[1];
		w7  = w_q[9];
		w2  = w_q[14];
		g0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
		g1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
		wt = (ctl.t < 6'd16) ? msg_word : (w16 + g0 + w7 + g1);
		s1 = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + ROUND_K[ctl.t] + wt;
		s0 = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0 + maj;
	end

	assign rd_word = h_q[rd_index];

	// Schedule window shifts one word per round; working words hold no reset.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (ctl.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	// Hash words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end
endmodule

>>> rtl/core/sha256_message_hasher.sv
// Top level: SHA-256 hasher fed one byte per item.
// Usage:
//   Input channel (in_valid/in_stall/in_item): one item per message byte;
//   byte_present marks a byte, end_of_message closes the message. An end
//   item without a byte hashes the pending bytes (the empty message if
//   none); an item with neither bit does nothing.
//   Output channel (out_valid/out_stall/out_item): after an end item eight
//   items H0..H7 follow in order, last_word set on H7.
// Timing:
//   A byte that does not fill a block is stored. The byte that fills a
//   block starts a compression: one load, 64 rounds of the shared round
//   unit, one fold. An end item runs one or two padded blocks (two when 56
//   or more bytes are pending), then the eight words go out at one per
//   cycle while out_stall is low. The sequencer holds in_stall high while
//   it pads, compresses or emits; a stalled output item holds steady.
// Reset:
//   arst_n loads the initial hash values and clears the length count and
//   the sequencer; there is no clearing pass.
module sha256_message_hasher (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  sha256_pkg::in_item_t   in_item,
	output logic                   out_valid,
	input  logic                   out_stall,
	output sha256_pkg::out_item_t  out_item
);
	import sha256_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
	} state_t;

	state_t      state_q;
	logic [60:0] len_q;
	logic [31:0] buf_q [16];
	logic [5:0]  t_q;
	logic [5:0]  pad_i_q;
	logic        final_q;    // compressing the padded blocks
	logic        second_q;   // another padded block follows
	logic [2:0]  idx_q;
	rnd_ctl_t    ctl;
	logic [31:0] msg_word, rd_word;
	logic        acc;
	logic [63:0] bits;
	logic [4:0]  len_lsb;    // byte lane of the next message byte
	logic [4:0]  pad_lsb;    // byte lane of the padding byte
	logic [5:0]  bits_lsb;   // length byte for the current padding slot

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign bits     = {len_q, 3'b000};
	assign msg_word = buf_q[t_q[3:0]];
	assign len_lsb  = {~len_q[1:0], 3'b000};
	assign pad_lsb  = {~pad_i_q[1:0], 3'b000};
	assign bits_lsb = {~pad_i_q[2:0], 3'b000};

	always_comb begin
		ctl       = '0;
		ctl.t     = t_q;
		ctl.load  = (state_q == ST_LOAD);
		ctl.round = (state_q == ST_ROUND);
		ctl.fold  = (state_q == ST_FOLD);
		ctl.init  = (state_q == ST_EMIT) && !out_stall && (idx_q == 3'd7);
	end

	sha256_compress_core u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.msg_word (msg_word),
		.rd_index (idx_q),
		.rd_word  (rd_word)
	);

	assign out_valid            = (state_q == ST_EMIT);
	assign out_item.digest_word = rd_word;
	assign out_item.word_index  = idx_q;
	assign out_item.last_word   = (idx_q == 3'd7);

	// Block buffer as big-endian words: bytes, then one padding byte per cycle.
	always_ff @(posedge clk) begin
		if (acc && in_item.byte_present) begin
			buf_q[len_q[5:2]][len_lsb +: 8] <= in_item.data_byte;
		end else if (state_q == ST_PAD) begin
			if (pad_i_q >= LEN_START && !second_q)
				buf_q[pad_i_q[5:2]][pad_lsb +: 8] <= bits[bits_lsb +: 8];
			else if (pad_i_q == len_q[5:0] && !final_q)
				buf_q[pad_i_q[5:2]][pad_lsb +: 8] <= PAD_BYTE;
			else
				buf_q[pad_i_q[5:2]][pad_lsb +: 8] <= 8'h00;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_q    <= '0;
			t_q      <= '0;
			pad_i_q  <= '0;
			final_q  <= 1'b0;
			second_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						logic [60:0] nl;
						nl = in_item.byte_present ? len_q + 61'd1 : len_q;
						len_q <= nl;
						final_q <= 1'b0;
						if (in_item.byte_present && nl[5:0] == 6'd0) begin
							second_q <= in_item.end_of_message;
							state_q <= ST_LOAD;
						end else if (in_item.end_of_message) begin
							pad_i_q  <= nl[5:0];
							second_q <= (nl[5:0] >= LEN_START);
							state_q  <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// final_q marks that the 0x80 is already placed
					pad_i_q <= pad_i_q + 6'd1;
					if (pad_i_q == 6'd63) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					t_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					t_q <= t_q + 6'd1;
					if (t_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					// after a full data block, pending end item pads now
					if (!final_q && second_q) begin
						second_q <= 1'b0;
						final_q  <= 1'b0;
						pad_i_q  <= 6'd0;
						state_q  <= ST_PAD;
					end else if (final_q && second_q) begin
						second_q <= 1'b0;
						pad_i_q  <= 6'd0;
						state_q  <= ST_PAD;
					end else if (final_q) begin
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (!out_stall) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							len_q   <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// padding pass always ends in a padded compression
			if (state_q == ST_PAD && pad_i_q == 6'd63) final_q <= 1'b1;
		end
	end
endmodule

>>> verif/tb_sha256_message_hasher.sv
// Testbench for the byte-fed SHA-256 hasher: directed and random messages against a local digest model.
module tb_sha256_message_hasher;
	timeunit 1ns;
	timeprecision 1ps;
	import sha256_pkg::*;

	// Digest model and queue of expected digest words
	class digest_board;
		logic [31:0] hash_h [8];
		logic [7:0]  blk [64];
		logic [60:0] msg_len;
		out_item_t   pending_words [$];
		int          fail_count;

		function new();
			hash_h = INIT_H;
			msg_len = '0;
			fail_count = 0;
			foreach (blk[i]) blk[i] = 8'h00;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [16];
			logic [31:0] a, b, c, d, e, f, g, h, s0, s1, t1, t2, g0, g1;
			for (int t = 0; t < 16; t++)
				w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
			{a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
				hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
			for (int t = 0; t < 64; t++) begin
				if (t >= 16) begin
					g0 = rotr(w[(t-15)&15], 7) ^ rotr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
					g1 = rotr(w[(t-2)&15], 17) ^ rotr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
					w[t&15] = w[t&15] + g0 + w[(t-7)&15] + g1;
				end
				s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
				t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_K[t] + w[t&15];
				s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
				t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
			hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
		endfunction

		// Note one accepted input item
		function void note_input(in_item_t it);
			int tail;
			logic [63:0] bits;
			out_item_t o;
			if (it.byte_present) begin
				blk[msg_len[5:0]] = it.data_byte;
				msg_len = msg_len + 1;
				if (msg_len[5:0] == 0) compress();
			end
			if (!it.end_of_message) return;
			tail = msg_len[5:0];
			blk[tail] = PAD_BYTE;
			for (int i = tail + 1; i < 64; i++) blk[i] = 8'h00;
			if (tail >= LEN_START) begin
				compress();
				for (int i = 0; i < 56; i++) blk[i] = 8'h00;
			end
			bits = {msg_len, 3'b000};
			for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
			compress();
			for (int i = 0; i < 8; i++) begin
				o.digest_word = hash_h[i];
				o.word_index = i[2:0];
				o.last_word = (i == 7);
				pending_words.push_back(o);
			end
			hash_h = INIT_H;
			msg_len = '0;
		endfunction

		// Check one accepted digest word
		function void check_word(out_item_t got);
			out_item_t exp_w;
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual %h/%0d/%0b", $realtime,
					got.digest_word, got.word_index, got.last_word);
				fail_count++;
				return;
			end
			exp_w = pending_words.pop_front();
			if (got.digest_word !== exp_w.digest_word) begin
				$display("%0t: digest_word: expected %h, actual %h", $realtime,
					exp_w.digest_word, got.digest_word);
				fail_count++;
			end
			if (got.word_index !== exp_w.word_index) begin
				$display("%0t: word_index: expected %0d, actual %0d", $realtime,
					exp_w.word_index, got.word_index);
				fail_count++;
			end
			if (got.last_word !== exp_w.last_word) begin
				$display("%0t: last_word: expected %0b, actual %0b", $realtime,
					exp_w.last_word, got.last_word);
				fail_count++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_item;

	digest_board board;
	int unsigned cycle_count;
	bit          quiet_phase;
	bit          long_hold;
	bit          hold_done;

	sha256_message_hasher i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Send one item; returns once it is accepted
	task automatic send_item(logic [7:0] b, logic p, logic e);
		in_item_t it;
		it.data_byte = b;
		it.byte_present = p;
		it.end_of_message = e;
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		board.note_input(it);
	endtask

	// Drop valid for a random burst, sometimes
	task automatic maybe_gap();
		int n;
		if (quiet_phase || $urandom_range(3) != 0) return;
		n = $urandom_range(1, 10);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_message(int len);
		for (int i = 0; i < len; i++) begin
			send_item(8'($urandom_range(255)), 1'b1, 1'b0);
			maybe_gap();
		end
		send_item(8'($urandom_range(255)), 1'b0, 1'b1);
		maybe_gap();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_words.size() != 0) @(posedge clk);
	endtask

	// Receiver: random stall bursts plus one long hold
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold && !hold_done) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
			end else if (!quiet_phase && $urandom_range(3) == 0) begin
				n = $urandom_range(1, 10);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				n = $urandom_range(0, 8);
				repeat (n) @(posedge clk);
			end else
				@(posedge clk);
		end
	end

	// Result monitor
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall) board.check_word(out_item);

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 600000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int sent, len;
		board = new();
		cycle_count = 0;
		quiet_phase = 1'b0;
		long_hold = 1'b0;
		hold_done = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, idle items, byte extremes, padding boundaries
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b0);
		send_item(8'h5a, 1'b1, 1'b1);
		wait_drained();
		send_message(55);
		send_message(56);
		wait_drained();

		// Receiver holds off long while the sender keeps going
		long_hold = 1'b1;
		send_message(3);
		send_message(2);
		send_message(1);
		while (!hold_done) @(posedge clk);
		wait_drained();

		// Random messages, mostly short, some spanning blocks
		sent = 0;
		while (sent < 230) begin
			case ($urandom_range(9))
				0: len = 0;
				1: len = $urandom_range(63, 70);
				2: len = $urandom_range(52, 60);
				default: len = $urandom_range(1, 12);
			endcase
			if ($urandom_range(4) == 0) begin
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
				sent++;
			end
			send_message(len);
			sent += len + 1;
			if ($urandom_range(7) == 0) wait_drained();
		end

		// Final part without idling
		quiet_phase = 1'b1;
		send_message(8);
		send_message(64);
		wait_drained();
		repeat (100) @(posedge clk);
		if (board.fail_count == 0 && board.pending_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

>>> sim.f
rtl/core/sha256_pkg.sv
rtl/core/sha256_round.sv
rtl/core/sha256_message_hasher.sv
verif/tb_sha256_message_hasher.sv
